FILE: hw/rtl/rusi_pkg.sv
// ----------------------------------------------------------------------------
// rusi_pkg: shared types and helpers for the ray / unit sphere intersect unit
// Request and result payloads, pipeline tag groups, fixed-point rounding.
// ----------------------------------------------------------------------------
package rusi_pkg;

	// Fraction bits of a unit direction component (Q2.30)
	localparam int UNIT_SHIFT = 30;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} ray_in_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} ray_out_t;

	// Travels alongside the length square root
	typedef struct packed {
		logic [2:0][31:0] s;
		logic [2:0]       neg;
		logic [2:0][31:0] an;
		logic             zero;
	} norm_tag_t;

	// Travels alongside the normalizing divider
	typedef struct packed {
		logic [2:0][31:0] s;
		logic [2:0]       neg;
		logic             zero;
	} div_tag_t;

	// Travels alongside the discriminant square root
	typedef struct packed {
		logic [2:0][31:0] s;
		logic [2:0][31:0] v;
		logic [35:0]      h;
		logic             miss;
	} back_tag_t;

	// Round x / 2^30 to nearest, ties away from zero
	function automatic logic signed [63:0] rnd30(input logic signed [63:0] x);
		logic [63:0] mag;
		logic [63:0] m;
		begin
			mag = x[63] ? (~x + 64'd1) : x;
			m   = (mag + (64'd1 << (UNIT_SHIFT - 1))) >> UNIT_SHIFT;
			rnd30 = x[63] ? $signed(~m + 64'd1) : $signed(m);
		end
	endfunction

endpackage

FILE: hw/rtl/rusi_isqrt.sv
// ----------------------------------------------------------------------------
// rusi_isqrt: pipelined integer square root
// Floor square root, one result bit per register stage, tag carried along.
// ----------------------------------------------------------------------------
module rusi_isqrt #(
	parameter int XW = 64,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [XW-1:0] x_in,
	input  logic [TW-1:0] tag_in,
	output logic          out_valid,
	output logic [XW/2-1:0] root_out,
	output logic [TW-1:0] tag_out
);
	localparam int RW  = XW / 2;
	localparam int RMW = RW + 3;

	logic [XW-1:0]  x_s    [1:RW];
	logic [RMW-1:0] rem_s  [1:RW];
	logic [RW-1:0]  root_s [1:RW];
	logic [TW-1:0]  tag_s  [1:RW];
	logic           vld_s  [1:RW];

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [XW-1:0]  x_src;
		logic [RMW-1:0] rem_src;
		logic [RW-1:0]  root_src;
		logic [TW-1:0]  tag_src;
		logic           vld_src;
		logic [RMW-1:0] cur;
		logic [RMW-1:0] trial;
		logic           take;

		if (k == 0) begin : g_first
			assign x_src    = x_in;
			assign rem_src  = '0;
			assign root_src = '0;
			assign tag_src  = tag_in;
			assign vld_src  = in_valid;
		end else begin : g_next
			assign x_src    = x_s[k];
			assign rem_src  = rem_s[k];
			assign root_src = root_s[k];
			assign tag_src  = tag_s[k];
			assign vld_src  = vld_s[k];
		end

		// bring down the next bit pair, try 4*root+1
		assign cur   = {rem_src[RMW-3:0], x_src[XW-1-2*k -: 2]};
		assign trial = {1'b0, root_src, 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_src;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]    <= x_src;
				rem_s[k+1]  <= take ? (cur - trial) : cur;
				root_s[k+1] <= {root_src[RW-2:0], take};
				tag_s[k+1]  <= tag_src;
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign root_out  = root_s[RW];
	assign tag_out   = tag_s[RW];

endmodule

FILE: hw/rtl/rusi_div.sv
// ----------------------------------------------------------------------------
// rusi_div: pipelined restoring divider, three lanes on one divisor
// One quotient bit per register stage; the quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module rusi_div #(
	parameter int NW = 62,
	parameter int DW = 32,
	parameter int QW = 31,
	parameter int TW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [2:0][NW-1:0]  n_in,
	input  logic [DW-1:0]       d_in,
	input  logic [TW-1:0]       tag_in,
	output logic                out_valid,
	output logic [2:0][QW-1:0]  q_out,
	output logic [TW-1:0]       tag_out
);
	logic [2:0][NW-1:0] n_s   [1:QW];
	logic [2:0][DW-1:0] r_s   [1:QW];
	logic [2:0][QW-1:0] q_s   [1:QW];
	logic [DW-1:0]      d_s   [1:QW];
	logic [TW-1:0]      tag_s [1:QW];
	logic               vld_s [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [2:0][NW-1:0] n_src;
		logic [2:0][DW-1:0] r_src;
		logic [2:0][QW-1:0] q_src;
		logic [DW-1:0]      d_src;
		logic [TW-1:0]      tag_src;
		logic               vld_src;
		logic [2:0][DW-1:0] r_nxt;
		logic [2:0][QW-1:0] q_nxt;

		if (k == 0) begin : g_first
			assign n_src   = n_in;
			assign d_src   = d_in;
			assign tag_src = tag_in;
			assign vld_src = in_valid;
			assign q_src   = '0;
			for (genvar l = 0; l < 3; l++) begin : g_init
				assign r_src[l] = DW'(n_in[l][NW-1:QW]);
			end
		end else begin : g_next
			assign n_src   = n_s[k];
			assign r_src   = r_s[k];
			assign q_src   = q_s[k];
			assign d_src   = d_s[k];
			assign tag_src = tag_s[k];
			assign vld_src = vld_s[k];
		end

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				logic [DW:0] t;
				t = {r_src[l], n_src[l][QW-1-k]};
				if (t >= {1'b0, d_src}) begin
					r_nxt[l] = DW'(t - {1'b0, d_src});
					q_nxt[l] = {q_src[l][QW-2:0], 1'b1};
				end else begin
					r_nxt[l] = DW'(t);
					q_nxt[l] = {q_src[l][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_src;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1]   <= n_src;
				r_s[k+1]   <= r_nxt;
				q_s[k+1]   <= q_nxt;
				d_s[k+1]   <= d_src;
				tag_s[k+1] <= tag_src;
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign q_out     = q_s[QW];
	assign tag_out   = tag_s[QW];

endmodule

FILE: hw/rtl/ray_unit_sphere_intersect_unit.sv
// ----------------------------------------------------------------------------
// ray_unit_sphere_intersect_unit: ray against the unit sphere at the origin
// Normalizes the direction, tests the ray, returns the nearer hit point.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on src_valid/src_ready/src_data (start point and direction,
//   signed Q16.16). One result per request leaves on res_valid/res_ready/
//   res_data in request order: hit flag and nearest point, zero on a miss.
//   Throughput: one request per cycle while no result waits untaken. The
//   pipeline has 95 register stages: the 32-stage length square root,
//   the 31-stage normalizing divider, the 17-stage discriminant square root
//   and 15 arithmetic stages around them.
//   The whole pipeline advances together. When the receiver holds res_ready
//   low with a result waiting, every stage holds, bubbles included, and
//   src_ready drops until the result is taken.
//   Reset clears all valid bits; the block is ready in the first cycle after.
//   Zero directions, tangent rays, origins inside the sphere and spheres
//   behind the origin report a miss; point coordinates saturate.
// ----------------------------------------------------------------------------
module ray_unit_sphere_intersect_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  rusi_pkg::ray_in_t  src_data,
	output logic               res_valid,
	input  logic               res_ready,
	output rusi_pkg::ray_out_t res_data
);
	// global advance: move everything unless a result waits untaken
	logic en;
	assign en        = !res_valid || res_ready;
	assign src_ready = en;

	// ---- stage 1: magnitudes and largest magnitude ----
	logic [2:0][31:0] s_in, d_in, a_c;
	logic [31:0]      mx_c;

	always_comb begin
		s_in = {src_data.start_z, src_data.start_y, src_data.start_x};
		d_in = {src_data.dir_z, src_data.dir_y, src_data.dir_x};
		mx_c = '0;
		for (int i = 0; i < 3; i++) begin
			a_c[i] = d_in[i][31] ? (~d_in[i] + 32'd1) : d_in[i];
			if (a_c[i] > mx_c) mx_c = a_c[i];
		end
	end

	logic             v_s1;
	logic [2:0][31:0] s_s1, a_s1;
	logic [2:0]       neg_s1;
	logic [31:0]      mx_s1;

	// ---- stage 2: shift up until the largest component reaches 2^30 ----
	logic [4:0]       shamt_c;
	logic [2:0][31:0] an_c;

	always_comb begin
		logic [4:0] msb;
		msb = '0;
		for (int b = 0; b < 32; b++) begin
			if (mx_s1[b]) msb = 5'(b);
		end
		shamt_c = (msb >= 5'd30) ? 5'd0 : (5'd30 - msb);
		for (int i = 0; i < 3; i++) an_c[i] = a_s1[i] << shamt_c;
	end

	logic             v_s2, zero_s2;
	logic [2:0][31:0] s_s2, an_s2;
	logic [2:0]       neg_s2;

	// ---- stage 3: squares; stage 4: sum of squares ----
	logic             v_s3, zero_s3;
	logic [2:0][31:0] s_s3, an_s3;
	logic [2:0]       neg_s3;
	logic [2:0][63:0] sq_s3;

	logic             v_s4;
	logic [63:0]      sum_s4;
	rusi_pkg::norm_tag_t nt_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= src_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1   <= s_in;
			a_s1   <= a_c;
			mx_s1  <= mx_c;
			for (int i = 0; i < 3; i++) neg_s1[i] <= d_in[i][31];

			s_s2    <= s_s1;
			an_s2   <= an_c;
			neg_s2  <= neg_s1;
			zero_s2 <= (mx_s1 == '0);

			s_s3    <= s_s2;
			an_s3   <= an_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			for (int i = 0; i < 3; i++) sq_s3[i] <= an_s2[i] * an_s2[i];

			sum_s4     <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			nt_s4.s    <= s_s3;
			nt_s4.neg  <= neg_s3;
			nt_s4.an   <= an_s3;
			nt_s4.zero <= zero_s3;
		end
	end

	// ---- length: floor square root of the sum of squares ----
	logic                len_vld;
	logic [31:0]         len;
	rusi_pkg::norm_tag_t nt;

	rusi_isqrt #(
		.XW(64),
		.TW($bits(rusi_pkg::norm_tag_t))
	) u_len_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.x_in     (sum_s4),
		.tag_in   (nt_s4),
		.out_valid(len_vld),
		.root_out (len),
		.tag_out  (nt)
	);

	// ---- unit direction: round(a * 2^30 / len) ----
	logic [2:0][61:0]   num_c;
	rusi_pkg::div_tag_t dt_in, dt;
	logic               div_vld;
	logic [2:0][30:0]   q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = {nt.an[i], 30'd0} + {31'd0, len[31:1]};
		end
		dt_in.s    = nt.s;
		dt_in.neg  = nt.neg;
		dt_in.zero = nt.zero;
	end

	rusi_div #(
		.NW(62),
		.DW(32),
		.QW(31),
		.TW($bits(rusi_pkg::div_tag_t))
	) u_norm_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (len_vld),
		.n_in     (num_c),
		.d_in     (len),
		.tag_in   (dt_in),
		.out_valid(div_vld),
		.q_out    (q),
		.tag_out  (dt)
	);

	// ---- stages 6..13: h, perpendicular offset, discriminant ----
	logic             v_s6, zero_s6;
	logic [2:0][31:0] s_s6, v6_s6;

	logic                     v_s7, zero_s7;
	logic [2:0][31:0]         s_s7, v6_s7;
	logic signed [2:0][63:0]  sv_s7;

	logic             v_s8, zero_s8;
	logic [2:0][31:0] s_s8, v6_s8;
	logic signed [63:0] hraw_s8;

	logic             v_s9, zero_s9;
	logic [2:0][31:0] s_s9, v6_s9;
	logic signed [35:0] h_s9;

	logic             v_s10, zero_s10;
	logic [2:0][31:0] s_s10, v6_s10;
	logic signed [35:0] h_s10;
	logic signed [2:0][63:0] hv_s10;

	logic             v_s11, zero_s11, far_s11;
	logic [2:0][31:0] s_s11, v6_s11;
	logic signed [35:0] h_s11;
	logic [2:0][16:0] p_s11;

	logic             v_s12, miss_s12;
	logic [2:0][31:0] s_s12, v6_s12;
	logic signed [35:0] h_s12;
	logic [2:0][33:0] psq_s12;

	logic             v_s13;
	logic [33:0]      disc_s13;
	rusi_pkg::back_tag_t bt_s13;

	logic [2:0][39:0] p_c;
	logic             far_c;
	logic [35:0]      dsum_c;
	logic             dmiss_c;

	always_comb begin
		far_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			p_c[i] = 40'($signed(s_s10[i])) - 40'(rusi_pkg::rnd30(hv_s10[i]));
			if ($signed(p_c[i]) >= 40'sd65536 || $signed(p_c[i]) <= -40'sd65536) begin
				far_c = 1'b1;
			end
		end
		dsum_c  = 36'(psq_s12[0]) + 36'(psq_s12[1]) + 36'(psq_s12[2]);
		dmiss_c = miss_s12 || (dsum_c >= (36'd1 << 32));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s6  <= div_vld;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// restore the sign of each unit component
			s_s6    <= dt.s;
			zero_s6 <= dt.zero;
			for (int i = 0; i < 3; i++) begin
				v6_s6[i] <= dt.neg[i] ? (~{1'b0, q[i]} + 32'd1) : {1'b0, q[i]};
			end

			s_s7    <= s_s6;
			v6_s7   <= v6_s6;
			zero_s7 <= zero_s6;
			for (int i = 0; i < 3; i++) sv_s7[i] <= $signed(s_s6[i]) * $signed(v6_s6[i]);

			s_s8    <= s_s7;
			v6_s8   <= v6_s7;
			zero_s8 <= zero_s7;
			hraw_s8 <= sv_s7[0] + sv_s7[1] + sv_s7[2];

			s_s9    <= s_s8;
			v6_s9   <= v6_s8;
			zero_s9 <= zero_s8;
			h_s9    <= 36'(rusi_pkg::rnd30(hraw_s8));

			s_s10    <= s_s9;
			v6_s10   <= v6_s9;
			zero_s10 <= zero_s9;
			h_s10    <= h_s9;
			for (int i = 0; i < 3; i++) hv_s10[i] <= h_s9 * $signed(v6_s9[i]);

			s_s11    <= s_s10;
			v6_s11   <= v6_s10;
			zero_s11 <= zero_s10;
			h_s11    <= h_s10;
			far_s11  <= far_c;
			for (int i = 0; i < 3; i++) p_s11[i] <= p_c[i][16:0];

			s_s12    <= s_s11;
			v6_s12   <= v6_s11;
			h_s12    <= h_s11;
			miss_s12 <= zero_s11 || far_s11;
			for (int i = 0; i < 3; i++) psq_s12[i] <= $signed(p_s11[i]) * $signed(p_s11[i]);

			// drop the discriminant to zero on a miss; the flag rides along
			disc_s13    <= dmiss_c ? '0 : 34'((36'd1 << 32) - dsum_c);
			bt_s13.s    <= s_s12;
			bt_s13.v    <= v6_s12;
			bt_s13.h    <= h_s12;
			bt_s13.miss <= dmiss_c;
		end
	end

	// ---- s = floor(sqrt(disc)) ----
	logic                sq_vld;
	logic [16:0]         sq;
	rusi_pkg::back_tag_t bt;

	rusi_isqrt #(
		.XW(34),
		.TW($bits(rusi_pkg::back_tag_t))
	) u_disc_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s13),
		.x_in     (disc_s13),
		.tag_in   (bt_s13),
		.out_valid(sq_vld),
		.root_out (sq),
		.tag_out  (bt)
	);

	// ---- stages 14..16: nearer root, point, saturation ----
	logic               v_s14, miss_s14;
	logic [2:0][31:0]   s_s14, v6_s14;
	logic signed [36:0] t2_s14;
	logic signed [36:0] t2_c;

	logic               v_s15, miss_s15;
	logic [2:0][31:0]   s_s15;
	logic signed [2:0][63:0] pv_s15;

	logic               v_s16;
	rusi_pkg::ray_out_t res_s16;
	logic signed [2:0][63:0] pt_c;
	logic [2:0][31:0]   sat_c;

	assign t2_c = -37'($signed(bt.h)) - 37'($signed({1'b0, sq}));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pt_c[i] = 64'($signed(s_s15[i])) + rusi_pkg::rnd30(pv_s15[i]);
			if ($signed(pt_c[i]) > 64'sd2147483647) begin
				sat_c[i] = 32'h7FFF_FFFF;
			end else if ($signed(pt_c[i]) < -64'sd2147483648) begin
				sat_c[i] = 32'h8000_0000;
			end else begin
				sat_c[i] = pt_c[i][31:0];
			end
			if (miss_s15) sat_c[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
		end else if (en) begin
			v_s14 <= sq_vld;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s14    <= bt.s;
			v6_s14   <= bt.v;
			t2_s14   <= t2_c;
			miss_s14 <= bt.miss || t2_c[36];

			s_s15    <= s_s14;
			miss_s15 <= miss_s14;
			for (int i = 0; i < 3; i++) pv_s15[i] <= $signed(v6_s14[i]) * t2_s14;

			res_s16.hit     <= !miss_s15;
			res_s16.point_x <= sat_c[0];
			res_s16.point_y <= sat_c[1];
			res_s16.point_z <= sat_c[2];
		end
	end

	assign res_valid = v_s16;
	assign res_data  = res_s16;

`ifndef ASSERT_OFF
	// a miss carries an all-zero point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.hit |->
			res_data.point_x == '0 && res_data.point_y == '0 && res_data.point_z == '0)
		else $error("miss result with nonzero point");

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed under stall");

	// normalization leaves the length at or above 2^30
	a_len_norm: assert property (@(posedge clk) disable iff (!arst_n)
		len_vld && !nt.zero |-> len[31:30] != 2'b00)
		else $error("direction length below 2^30 after normalization");
`endif

endmodule
